FILE: design/mtf_pkg.sv
// shared constants, types and control structs for the move-to-front recent list
package mtf_pkg;

  localparam int DEPTH       = 128;
  localparam int DEFAULT_CAP = 100;
  localparam int KEY_W       = 21;
  localparam int CFG_W       = 8;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  // wide enough for a length plus one, a config value and the default capacity
  localparam int EXT_W       = $clog2(DEPTH + DEFAULT_CAP + (1 << CFG_W) + 1);

  // result field widths
  localparam int POS_W = 7;
  localparam int LEN_W = 8;
  localparam int DRP_W = 8;

  // request kinds
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef logic [KEY_W-1:0] key_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp_en;    // capture the compare result
    logic valid;     // cell lies inside the current list
    logic shift_en;  // take the key from the neighbor toward the head
  } cell_ctrl_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_ENC  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_e;

endpackage

FILE: design/mtf_cell.sv
// one list cell: holds a key, compares it with the search key, shifts toward the tail
module mtf_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtf_pkg::cell_ctrl_t ctrl_i,
  input  mtf_pkg::key_t      search_key_i,
  input  mtf_pkg::key_t      prev_key_i,
  output mtf_pkg::key_t      key_o,
  output logic               hit_o
);
  import mtf_pkg::*;

  key_t key_q;
  logic hit_q;

  // stored key, loaded from the neighbor on a shift
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en) begin
      key_q <= prev_key_i;
    end
  end

  // registered match flag, only for cells inside the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      hit_q <= ctrl_i.valid && (key_q == search_key_i);
    end
  end

  assign key_o = key_q;
  assign hit_o = hit_q;

endmodule

FILE: design/mtf_enc.sv
// turns the one-hot hit row into a present flag and a binary position
module mtf_enc (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [mtf_pkg::DEPTH-1:0] hit_i,
  output logic                      present_o,
  output logic [mtf_pkg::IDX_W-1:0] pos_o
);
  import mtf_pkg::*;

  logic             present_q;
  logic [IDX_W-1:0] pos_q;
  logic [IDX_W-1:0] pos_d;

  // at most one cell matches, so an or of the indexes gives the position
  always_comb begin
    pos_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_i[i]) begin
        pos_d = pos_d | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      pos_q     <= '0;
    end else if (en_i) begin
      present_q <= |hit_i;
      pos_q     <= pos_d;
    end
  end

  assign present_o = present_q;
  assign pos_o     = pos_q;

endmodule

FILE: design/move_to_front_recent_list.sv
// top level: request sequencer, cell row, position encoder and result register
// Each request runs through these steps in order: the beat is accepted and latched in idle,
// all cells compare their key in parallel, the match position is encoded, and the row shifts
// by a cell toward the tail while the length is updated. The result is loaded into the output
// register at the update step, and a new beat is taken only once the previous one has left
// the row; the finished result then waits in the output register while the next one runs.
// The update step holds while that register still has an unaccepted result, so output stalls
// lengthen the item by their duration.
// The list holds up to 128 keys; capacity 0 selects 100 entries, and a capacity
// above 128 is held at 128. Lowering the capacity trims the list at the next add.
module move_to_front_recent_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: max_entries
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // key_code[20:0], zero pad
  input  logic        s_axis_tuser_i,   // req_type
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // old_position[6:0], list_length[14:7],
                                        // dropped_count[22:15], zero pad
  output logic        m_axis_tuser_o    // was_present
);
  import mtf_pkg::*;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] max_entries_q;
  logic [CNT_W-1:0] count_q;
  key_t             key_q;
  logic             req_q;

  logic             out_valid_q;
  logic             out_present_q;
  logic [POS_W-1:0] out_pos_q;
  logic [LEN_W-1:0] out_len_q;
  logic [DRP_W-1:0] out_drop_q;

  cell_ctrl_t       ctrl    [DEPTH];
  key_t             cell_key[DEPTH];
  logic [DEPTH-1:0] hit;
  logic             present;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] limit;

  logic             in_fire;
  logic             can_write;
  logic             upd_fire;
  logic [EXT_W-1:0] cap;
  logic [EXT_W-1:0] len_raw;
  logic [EXT_W-1:0] len_new;
  logic [EXT_W-1:0] drop_new;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign can_write = !out_valid_q || m_axis_tready_i;
  assign upd_fire  = (state_q == ST_UPD) && can_write;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_CMP;
      ST_CMP:  state_d = ST_ENC;
      ST_ENC:  state_d = ST_UPD;
      ST_UPD:  if (can_write) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= '0;
    end else if (cfg_we_i) begin
      max_entries_q <= cfg_wdata_i;
    end
  end

  // request beat capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q <= s_axis_tdata_i[KEY_W-1:0];
      req_q <= s_axis_tuser_i;
    end
  end

  // shift limit: the hole left by the old copy, or the whole row
  assign limit = present ? pos : IDX_W'(DEPTH - 1);

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctrl[i].cmp_en   = (state_q == ST_CMP);
    assign ctrl[i].valid    = (CNT_W'(i) < count_q);
    assign ctrl[i].shift_en = upd_fire && (req_q == REQ_ADD) && (IDX_W'(i) <= limit);

    if (i == 0) begin : g_head
      mtf_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl[i]),
        .search_key_i (key_q),
        .prev_key_i   (key_q),
        .key_o        (cell_key[i]),
        .hit_o        (hit[i])
      );
    end else begin : g_body
      mtf_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl[i]),
        .search_key_i (key_q),
        .prev_key_i   (cell_key[i-1]),
        .key_o        (cell_key[i]),
        .hit_o        (hit[i])
      );
    end
  end

  // match position
  mtf_enc u_enc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (state_q == ST_ENC),
    .hit_i     (hit),
    .present_o (present),
    .pos_o     (pos)
  );

  // effective capacity
  always_comb begin
    cap = (max_entries_q == '0) ? EXT_W'(DEFAULT_CAP) : EXT_W'(max_entries_q);
    if (cap > EXT_W'(DEPTH)) begin
      cap = EXT_W'(DEPTH);
    end
  end

  // new length and trimmed entries
  always_comb begin
    len_raw  = present ? EXT_W'(count_q) : EXT_W'(count_q) + EXT_W'(1);
    len_new  = len_raw;
    drop_new = '0;
    if (req_q == REQ_CLEAR) begin
      len_new  = '0;
      drop_new = EXT_W'(count_q);
    end else if (len_raw > cap) begin
      len_new  = cap;
      drop_new = len_raw - cap;
    end
  end

  // list length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (upd_fire) begin
      count_q <= CNT_W'(len_new);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      out_present_q <= (req_q == REQ_ADD) && present;
      out_pos_q     <= (req_q == REQ_ADD) && present ? POS_W'(pos) : '0;
      out_len_q     <= LEN_W'(len_new);
      out_drop_q    <= DRP_W'(drop_new);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_present_q;
  assign m_axis_tdata_o  = {1'b0, out_drop_q, out_len_q, out_pos_q};

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("list length beyond storage depth");

  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ENC) |-> $onehot0(hit))
    else $error("key stored in more than one cell");

  a_pos_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_UPD) && present) |-> (CNT_W'(pos) < count_q))
    else $error("match position outside the list");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |=> (EXT_W'(count_q) <= $past(cap)))
    else $error("length above capacity after update");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("request accepted while one is in the row");

endmodule
